[hw/rtl/csrm_pkg.sv]
// ----------------------------------------------------------------------------
// csrm_pkg
// Shared types and codes for the seeded radius match block.
// ----------------------------------------------------------------------------
package csrm_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_CLUSTER = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  localparam int unsigned ETA_W = 16;
  localparam int unsigned PHI_W = 15;
  localparam int unsigned LIM_W = 32;
  localparam int unsigned CNT_OUT_W = 11;

  // One stored seed position.
  typedef struct packed {
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
  } seed_t;

  // Per-seed comparison result handed back to the controller.
  typedef struct packed {
    logic vld;
    logic hit;
  } match_res_t;

  localparam logic [LIM_W-1:0] DIST_SQ_RESET = 32'd377487;

endpackage

[hw/rtl/cluster_seeded_radius_match.sv]
// ----------------------------------------------------------------------------
// cluster_seeded_radius_match
// Start, cluster and ignored items load their result into the output register
// at the edge that accepts the item. A query walks the seed store one seed per
// cycle and loads its result once the last seed read has passed the distance
// unit; no item is taken meanwhile. The single read port of the seed memory
// sets the scan rate.
// Reset empties the store, clears the event threshold and restores the
// squared match radius to its default; seed memory contents are not cleared.
// ----------------------------------------------------------------------------
module cluster_seeded_radius_match #(
  parameter int unsigned MAX_SEEDS = 1024
) (
  input  logic        clk,
  input  logic        rst,

  // Configuration: squared match radius, 24 fraction bits.
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,

  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // energy[15:0], eta[31:16], phi[46:32], zero[47]
  input  logic [1:0]  s_tuser,   // action[1:0]

  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // matched[0], dropped[1], seed_count[12:2], zero[15:13]
);
  import csrm_pkg::*;

  // The count must hold MAX_SEEDS itself; the address only indexes entries.
  localparam int unsigned CNT_W  = $clog2(MAX_SEEDS + 1);
  localparam int unsigned ADDR_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEEDS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Input field unpacking.
  logic [15:0]               in_energy;
  logic signed [ETA_W-1:0]   in_eta;
  logic [PHI_W-1:0]          in_phi;
  action_t                   in_action;

  assign in_energy = s_tdata[15:0];
  assign in_eta    = $signed(s_tdata[31:16]);
  assign in_phi    = s_tdata[46:32];
  assign in_action = action_t'(s_tuser);

  // Block state outside the seed memory.
  logic [CNT_W-1:0]  total;
  logic [15:0]       threshold;
  logic [LIM_W-1:0]  limit;

  // Query scan registers.
  logic signed [ETA_W-1:0] q_eta;
  logic [PHI_W-1:0]        q_phi;
  logic [CNT_W-1:0]        rd_cnt;
  logic                    rd_vld;
  logic                    hit_acc;

  // Output register.
  logic                    out_matched;
  logic                    out_dropped;
  logic [CNT_W-1:0]        out_count;
  logic                    out_free;
  logic                    accept;

  // Memory and distance unit connections.
  logic                    mem_wen;
  logic                    mem_ren;
  seed_t                   mem_wdata;
  seed_t                   mem_rdata;
  match_res_t              dist_res;
  logic                    scan_issue;
  logic                    scan_done;
  logic                    store_ok;
  logic                    passes;

  // The output register frees up in the same cycle it is taken, so a new
  // item can be accepted while the previous result is being delivered.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // A cluster is stored only if it beats the event threshold and there is room.
  assign passes   = in_energy > threshold;
  assign store_ok = passes && (total != CNT_FULL);

  assign mem_wen         = accept && (in_action == ACT_CLUSTER) && store_ok;
  assign mem_wdata.eta   = in_eta;
  assign mem_wdata.phi   = in_phi;

  // The scan issues one read per cycle until every stored seed is read, then
  // waits for the last comparisons to drain out of the distance pipeline.
  assign scan_issue = (state == ST_SCAN) && (rd_cnt != total);
  assign mem_ren    = scan_issue;
  assign scan_done  = (state == ST_SCAN) && (rd_cnt == total) && !rd_vld && !dist_res.vld;

  csrm_seed_mem #(
    .DEPTH  (MAX_SEEDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (total[ADDR_W-1:0]),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (rd_cnt[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  csrm_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .seed_vld (rd_vld),
    .seed     (mem_rdata),
    .q_eta    (q_eta),
    .q_phi    (q_phi),
    .limit    (limit),
    .res      (dist_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      threshold <= '0;
      limit     <= DIST_SQ_RESET;
      rd_vld    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_issue;

      if (cfg_wen) begin
        limit <= cfg_wdata;
      end

      if (accept) begin
        case (in_action)
          ACT_START: begin
            total     <= '0;
            threshold <= in_energy;
          end
          ACT_CLUSTER: begin
            if (store_ok) begin
              total <= total + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // A query item reports only once its scan completes.
      if ((accept && (in_action != ACT_QUERY)) || scan_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Scan bookkeeping and result payload.
  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_QUERY)) begin
      q_eta   <= in_eta;
      q_phi   <= in_phi;
      rd_cnt  <= '0;
      hit_acc <= 1'b0;
    end else begin
      if (scan_issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (dist_res.hit) begin
        hit_acc <= 1'b1;
      end
    end

    if (accept) begin
      out_matched <= 1'b0;
      case (in_action)
        ACT_START: begin
          out_dropped <= 1'b0;
          out_count   <= '0;
        end
        ACT_CLUSTER: begin
          out_dropped <= passes && (total == CNT_FULL);
          out_count   <= store_ok ? total + 1'b1 : total;
        end
        default: begin
          out_dropped <= 1'b0;
          out_count   <= total;
        end
      endcase
    end else if (scan_done) begin
      out_matched <= hit_acc;
      out_dropped <= 1'b0;
      out_count   <= total;
    end
  end

  // Seed count is reported as its low bits, zero-extended when the count is narrow.
  assign m_tdata[0]     = out_matched;
  assign m_tdata[1]     = out_dropped;
  assign m_tdata[15:13] = '0;

  generate
    if (CNT_W >= CNT_OUT_W) begin : g_cnt_trunc
      assign m_tdata[12:2] = out_count[CNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign m_tdata[12:2] = {{(CNT_OUT_W-CNT_W){1'b0}}, out_count};
    end
  endgenerate

endmodule

[hw/rtl/csrm_seed_mem.sv]
// ----------------------------------------------------------------------------
// csrm_seed_mem
// Seed store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csrm_seed_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic               clk,
  input  logic               wen,
  input  logic [ADDR_W-1:0]  waddr,
  input  csrm_pkg::seed_t    wdata,
  input  logic               ren,
  input  logic [ADDR_W-1:0]  raddr,
  output csrm_pkg::seed_t    rdata
);
  import csrm_pkg::*;

  seed_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/csrm_dist.sv]
// ----------------------------------------------------------------------------
// csrm_dist
// Squared distance between the query point and one seed, checked against the limit; the squares are registered.
// ----------------------------------------------------------------------------
module csrm_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                seed_vld,
  input  csrm_pkg::seed_t                     seed,
  input  logic signed [csrm_pkg::ETA_W-1:0]   q_eta,
  input  logic [csrm_pkg::PHI_W-1:0]          q_phi,
  input  logic [csrm_pkg::LIM_W-1:0]          limit,
  output csrm_pkg::match_res_t                res
);
  import csrm_pkg::*;

  logic signed [ETA_W:0]       de;
  logic signed [PHI_W:0]       dp;
  logic signed [2*ETA_W+1:0]   de_prod;
  logic signed [2*PHI_W+1:0]   dp_prod;
  logic [2*ETA_W-1:0]          de_sq;
  logic [2*PHI_W-1:0]          dp_sq;
  logic                        sq_vld;
  logic [2*ETA_W:0]            d2;

  // Differences are exact: one extra bit each, no phi wrap.
  assign de = {q_eta[ETA_W-1], q_eta} - {seed.eta[ETA_W-1], seed.eta};
  assign dp = $signed({1'b0, q_phi}) - $signed({1'b0, seed.phi});
  assign de_prod = de * de;
  assign dp_prod = dp * dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= seed_vld;
    end
  end

  // The squares are non-negative and fit their low bits.
  always_ff @(posedge clk) begin
    de_sq <= de_prod[2*ETA_W-1:0];
    dp_sq <= dp_prod[2*PHI_W-1:0];
  end

  assign d2 = {1'b0, de_sq} + {{(2*ETA_W+1-2*PHI_W){1'b0}}, dp_sq};

  assign res.vld = sq_vld;
  assign res.hit = sq_vld && (d2 < {{(2*ETA_W+1-LIM_W){1'b0}}, limit});

endmodule

[tb/cluster_seeded_radius_match_test.sv]
// ----------------------------------------------------------------------------
// cluster_seeded_radius_match_test
// Self-checking bench for the seeded radius match block. Items are queued by
// a stimulus process and presented by a clocked driver that predicts each
// result the moment its item is accepted. A clocked monitor takes results
// under random back-pressure and compares every field against the oldest
// prediction. The run steps through several match radii and three idling
// patterns on the two streams.
// ----------------------------------------------------------------------------
module cluster_seeded_radius_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csrm_pkg::*;

  localparam int unsigned SEED_CAP = 1024;
  // Action code that the block must ignore apart from reporting its count.
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int unsigned REPORT_LIMIT = 10;

  // One input item as the bench sees it.
  typedef struct packed {
    logic [1:0]              code;
    logic [15:0]             energy;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
  } probe_t;

  // One result item; member order matches the concatenation used to unpack it.
  typedef struct packed {
    logic                 matched;
    logic                 dropped;
    logic [CNT_OUT_W-1:0] count;
  } tag_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // energy[15:0], eta[31:16], phi[46:32], zero[47]
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // matched[0], dropped[1], seed_count[12:2], zero[15:13]

  cluster_seeded_radius_match #(
    .MAX_SEEDS(SEED_CAP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The whole run is bounded well above the slowest legal schedule.
  initial begin
    #40000000;
    $display("cluster_seeded_radius_match_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Mirror of the block: seed positions of the current event, the number
  // stored, the latched threshold and the squared radius last written.
  // --------------------------------------------------------------------------
  logic signed [ETA_W-1:0] mirror_eta [SEED_CAP];
  logic [PHI_W-1:0]        mirror_phi [SEED_CAP];
  int unsigned             mirror_total = 0;
  logic [15:0]             mirror_threshold = '0;
  logic [LIM_W-1:0]        mirror_radius_sq = DIST_SQ_RESET;

  // Applies one accepted item to the mirror and returns the result it causes.
  function automatic tag_t seed_store_step(input probe_t p);
    tag_t t;
    longint de;
    longint dp;
    longint unsigned d2;
    t = '0;
    case (p.code)
      ACT_START: begin
        mirror_total = 0;
        mirror_threshold = p.energy;
      end
      ACT_CLUSTER: begin
        // Only a strictly higher energy makes a seed; a full store flags it.
        if (p.energy > mirror_threshold) begin
          if (mirror_total >= SEED_CAP) begin
            t.dropped = 1'b1;
          end else begin
            mirror_eta[mirror_total] = p.eta;
            mirror_phi[mirror_total] = p.phi;
            mirror_total++;
          end
        end
      end
      ACT_QUERY: begin
        // The sum of squares can exceed 32 bits, so it is held in 64.
        for (int i = 0; i < mirror_total; i++) begin
          de = longint'($signed(p.eta)) - longint'($signed(mirror_eta[i]));
          dp = longint'(p.phi) - longint'(mirror_phi[i]);
          d2 = longint'(de * de) + longint'(dp * dp);
          if (d2 < longint'(mirror_radius_sq)) begin
            t.matched = 1'b1;
            break;
          end
        end
      end
      default: begin
        // Ignored code: state is untouched, only the count is reported.
      end
    endcase
    t.count = mirror_total[CNT_OUT_W-1:0];
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, counters and idling knobs shared by stimulus, driver and monitor.
  // --------------------------------------------------------------------------
  probe_t      pending_items [$];
  tag_t        expected_tags [$];
  probe_t      on_bus;
  tag_t        seen_tag;
  tag_t        due_tag;
  int unsigned items_queued = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 72;

  // Positions of clusters sent in the current event, used to aim queries.
  logic [15:0] aim_eta [$];
  logic [14:0] aim_phi [$];
  logic [15:0] aim_threshold = '0;
  int          near_span = 700;

  // Driver: the item on the bus is predicted at the edge that accepts it, and
  // a new item (or an idle cycle) is put up whenever the slot is free.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_tags.push_back(seed_store_step(on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, on_bus.phi, on_bus.eta, on_bus.energy};
          s_tuser <= on_bus.code;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string why, input tag_t want, input tag_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected matched=%0b dropped=%0b count=%0d,",
               $realtime, why, want.matched, want.dropped, want.count,
               " got matched=%0b dropped=%0b count=%0d",
               got.matched, got.dropped, got.count);
    end
  endtask

  // Monitor: takes results under random back-pressure and checks each one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_tag = {m_tdata[0], m_tdata[1], m_tdata[12:2]};
        if (expected_tags.size() == 0) begin
          report_mismatch("result with no item pending", '0, seen_tag);
        end else begin
          due_tag = expected_tags.pop_front();
          results_checked++;
          if (seen_tag !== due_tag) begin
            report_mismatch("result mismatch", due_tag, seen_tag);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] code, input logic [15:0] energy,
                            input logic [15:0] eta, input logic [14:0] phi);
    pending_items.push_back({code, energy, eta, phi});
    items_queued++;
  endtask

  // Every item gives exactly one result, so equal counts mean the block is idle.
  task automatic wait_drained();
    while (results_checked != items_queued) @(negedge clk);
  endtask

  // Writes the squared radius once the block is idle and updates the mirror.
  task automatic write_radius(input logic [31:0] lim, input int span);
    wait_drained();
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_wen <= 1'b0;
    mirror_radius_sq = lim;
    near_span = span;
  endtask

  // Mostly well-formed events: a start, then a short mix of clusters around
  // the threshold and queries aimed near earlier clusters. Some runs skip the
  // start and carry on from the previous event; ignored codes are sprinkled in
  // and do not count toward the target.
  task automatic queue_random_events(input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    int unsigned k;
    logic [15:0] en;
    logic [15:0] eta;
    logic [14:0] phi;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_item(ACT_IGNORED, 16'($urandom), 16'($urandom), 15'($urandom));
      end else begin
        if (pick >= 12) begin
          case ($urandom_range(9))
            0: aim_threshold = 16'd0;
            1: aim_threshold = 16'hFFFF;
            default: aim_threshold = 16'($urandom_range(4095));
          endcase
          queue_item(ACT_START, aim_threshold, 16'($urandom), 15'($urandom));
          aim_eta.delete();
          aim_phi.delete();
          counted++;
        end
        repeat ($urandom_range(1, 14)) begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            case ($urandom_range(3))
              0: en = aim_threshold + 16'd1;
              1: en = aim_threshold;
              2: en = 16'($urandom_range(aim_threshold));
              default: en = 16'($urandom);
            endcase
            eta = 16'($urandom);
            phi = 15'($urandom);
            queue_item(ACT_CLUSTER, en, eta, phi);
            aim_eta.push_back(eta);
            aim_phi.push_back(phi);
            counted++;
          end else if (pick < 95) begin
            if (aim_eta.size() != 0 && $urandom_range(3) != 0) begin
              k = $urandom_range(aim_eta.size() - 1);
              eta = 16'(int'(aim_eta[k]) + int'($urandom_range(2 * near_span)) - near_span);
              phi = 15'(int'(aim_phi[k]) + int'($urandom_range(2 * near_span)) - near_span);
            end else begin
              eta = 16'($urandom);
              phi = 15'($urandom);
            end
            queue_item(ACT_QUERY, 16'($urandom), eta, phi);
            counted++;
          end else begin
            queue_item(ACT_IGNORED, 16'($urandom), 16'($urandom), 15'($urandom));
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset radius (614 raw units is just inside it,
    // 615 just outside). Items before any start see threshold 0 and an empty
    // store.
    queue_item(ACT_QUERY,   16'd0,     16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd0,     16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd1,     16'd0,       15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'd614,     15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'd615,     15'd0);
    queue_item(ACT_QUERY,   16'd0,     -16'sd614,   15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'd0,       15'd614);
    queue_item(ACT_QUERY,   16'd0,     16'd0,       15'd615);
    queue_item(ACT_IGNORED, 16'hFFFF,  16'h8000,    15'h7FFF);
    // A threshold at full scale lets nothing through.
    queue_item(ACT_START,   16'hFFFF,  16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'hFFFF,  16'd0,       15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'd0,       15'd0);
    // Seeds at opposite corners of the eta range, phi above two pi.
    queue_item(ACT_START,   16'd1000,  16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd1000,  16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd1001,  16'h8000,    15'h7FFF);
    queue_item(ACT_CLUSTER, 16'hFFFF,  16'h7FFF,    15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'h8000,    15'h7FFF);
    queue_item(ACT_QUERY,   16'd0,     16'h7FFF,    15'h7FFF);
    queue_item(ACT_QUERY,   16'd0,     16'd0,       15'd25736);
    queue_item(ACT_START,   16'd0,     16'd0,       15'd0);

    // A zero radius never matches, not even on the seed itself.
    write_radius(32'd0, 64);
    queue_item(ACT_START,   16'd0,     16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd1,     16'd123,     15'd456);
    queue_item(ACT_QUERY,   16'd0,     16'd123,     15'd456);
    queue_random_events(80);

    // Largest radius: sums of squares above 32 bits must still miss.
    write_radius(32'hFFFF_FFFF, 3000);
    send_idle_pct = 72;
    recv_idle_pct = 27;
    queue_item(ACT_START,   16'd0,     16'd0,       15'd0);
    queue_item(ACT_CLUSTER, 16'd1,     16'h8000,    15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'h7FFF,    15'd0);
    queue_item(ACT_QUERY,   16'd0,     16'h7FFF,    15'h7FFF);
    queue_item(ACT_QUERY,   16'd0,     16'h7FFF,    15'd1);
    queue_random_events(80);

    // Random radii, each with a query spread a little wider than the radius.
    repeat (2) begin
      r = $urandom_range(1, 4000);
      write_radius(r * r + $urandom_range(2 * r), int'(r + r / 4 + 2));
      queue_random_events(80);
    end

    // Back to the default radius with no idling on either stream.
    write_radius(DIST_SQ_RESET, 700);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_events(100);

    r = $urandom_range(1, 4000);
    write_radius(r * r + $urandom_range(2 * r), int'(r + r / 4 + 2));
    queue_random_events(100);

    // Wait past the end of a longest query so stray results show up.
    wait_drained();
    repeat (SEED_CAP + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("cluster_seeded_radius_match_test: done, clean");
    end else begin
      $display("cluster_seeded_radius_match_test: done, errors");
    end
    $finish;
  end

endmodule
